[src/swmed_pkg.sv]
// Shared types and constants for the sliding-window median filter.
`default_nettype none

package swmed_pkg;

    // Configuration port layout
    localparam int unsigned ADDR_BITS = 3;
    localparam int unsigned CFG_BITS  = 7;

    localparam logic                REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

    // Operation broadcast to every cell of the sorted chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_EVICT,
        OP_COMPACT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     restart;
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_PICK
    } state_t;

endpackage

`default_nettype wire

[src/swmed_cell.sv]
// One cell of the sorted window chain: a sample, its age and a valid flag.
`default_nettype none

module swmed_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_BITS    = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire swmed_pkg::cell_ctrl_t         ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic        [AGE_BITS-1:0]    lim,
    input  wire logic                          dn_vld,
    input  wire logic signed [SAMPLE_BITS-1:0] dn_val,
    input  wire logic        [AGE_BITS-1:0]    dn_age,
    input  wire logic                          up_vld,
    input  wire logic signed [SAMPLE_BITS-1:0] up_val,
    input  wire logic        [AGE_BITS-1:0]    up_age,
    output logic                               vld,
    output logic signed [SAMPLE_BITS-1:0]      val,
    output logic        [AGE_BITS-1:0]         age
);

    logic                          vld_reg;
    logic                          vld_next;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic        [AGE_BITS-1:0]    age_reg;
    logic        [AGE_BITS-1:0]    age_next;
    logic                          gt_self;
    logic                          gt_dn;

    assign gt_self = vld_reg && (val_reg > sample);
    assign gt_dn   = dn_vld && (dn_val > sample);

    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        age_next = age_reg;
        unique case (ctrl.op)
            swmed_pkg::OP_HOLD:
            begin
                vld_next = vld_reg;
            end
            swmed_pkg::OP_EVICT:
            begin
                // drop samples that fall out of the window
                if (vld_reg && (ctrl.restart || (age_reg >= lim)))
                begin
                    vld_next = 1'b0;
                end
            end
            swmed_pkg::OP_COMPACT:
            begin
                // pull a hole upward: valid cells slide down one place
                if (!vld_reg && up_vld)
                begin
                    vld_next = 1'b1;
                    val_next = up_val;
                    age_next = up_age;
                end
                else if (vld_reg && !dn_vld)
                begin
                    vld_next = 1'b0;
                end
            end
            swmed_pkg::OP_INSERT:
            begin
                priority if (gt_dn)
                begin
                    vld_next = 1'b1;
                    val_next = dn_val;
                    age_next = dn_age + AGE_BITS'(1);
                end
                else if (gt_self || (!vld_reg && dn_vld))
                begin
                    vld_next = 1'b1;
                    val_next = sample;
                    age_next = '0;
                end
                else if (vld_reg)
                begin
                    age_next = age_reg + AGE_BITS'(1);
                end
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign vld = vld_reg;
    assign val = val_reg;
    assign age = age_reg;

endmodule

`default_nettype wire

[src/sliding_window_median_top.sv]
// Running median filter over a window of recent signed samples.
//
// Input channel: sample and restart move on an in_valid/in_ready transfer.
// Output channel: median_doubled (twice the median, one fraction bit) moves on
// an out_valid/out_ready transfer. A result appears only when the window holds
// exactly window_size samples; until then a sample gives no result.
// Configuration: window_size at APB byte address 0 (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW). Write it only while idle, then restart.
// Samples sit in a chain of MAX_WINDOW cells kept in ascending order. Each
// sample first evicts the samples leaving the window, then each freed slot
// travels up the chain until no hole is left, then the new sample is inserted
// and the median is picked; in_ready stays low until then. The result is shown
// the cycle after the median is picked from the chain.
// The output register holds a result while the receiver stalls; the next
// sample is taken meanwhile, and its pick waits until the register frees.
// Reset empties the window, drops any pending result and sets window_size to 3.
`default_nettype none

module sliding_window_median_top #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [swmed_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire logic                                restart,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    output logic signed [SAMPLE_BITS:0]              median_doubled,
    output logic                                     out_valid,
    input  wire logic                                out_ready
);

    localparam int AGE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Configuration register
    logic [swmed_pkg::CFG_BITS-1:0] window_size_reg;
    logic [swmed_pkg::CFG_BITS-1:0] window_size_next;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == swmed_pkg::REG_WINDOW_SIZE);
    assign prdata    = (paddr[2] == swmed_pkg::REG_WINDOW_SIZE)
                     ? {{(32 - swmed_pkg::CFG_BITS){1'b0}}, window_size_reg} : '0;
    assign window_size_next = cfg_write ? pwdata[swmed_pkg::CFG_BITS-1:0] : window_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swmed_pkg::WINDOW_SIZE_RESET;
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    // Effective window length and the taps it selects
    logic [31:0]         k_wide;
    logic [AGE_BITS-1:0] k_lim;
    logic [AGE_BITS-1:0] lo_idx;
    logic [AGE_BITS-1:0] hi_idx;

    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            k_wide = 32'd1;
        end
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            k_wide = 32'(MAX_WINDOW);
        end
        else
        begin
            k_wide = 32'(window_size_reg);
        end
    end

    assign k_lim  = AGE_BITS'(k_wide - 32'd1);
    assign lo_idx = AGE_BITS'((k_wide - 32'd1) >> 1);
    assign hi_idx = AGE_BITS'(k_wide >> 1);

    // Sequencer
    swmed_pkg::state_t     state_reg;
    swmed_pkg::state_t     state_next;
    swmed_pkg::cell_ctrl_t cell_ctrl;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic                          gap;
    logic                          full;
    logic                          pick_load;

    // Cell chain with a fixed bottom (always valid, never greater) and empty top
    logic                          ext_vld [MAX_WINDOW+2];
    logic signed [SAMPLE_BITS-1:0] ext_val [MAX_WINDOW+2];
    logic        [AGE_BITS-1:0]    ext_age [MAX_WINDOW+2];
    logic        [MAX_WINDOW-1:0]  vld_all;
    logic signed [SAMPLE_BITS-1:0] val_all [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]  gap_bits;

    assign ext_vld[0]            = 1'b1;
    assign ext_val[0]            = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign ext_age[0]            = '0;
    assign ext_vld[MAX_WINDOW+1] = 1'b0;
    assign ext_val[MAX_WINDOW+1] = '0;
    assign ext_age[MAX_WINDOW+1] = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swmed_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_BITS    (AGE_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (cell_ctrl),
            .sample ((cell_ctrl.op == swmed_pkg::OP_INSERT) ? sample_reg : sample),
            .lim    (k_lim),
            .dn_vld (ext_vld[i]),
            .dn_val (ext_val[i]),
            .dn_age (ext_age[i]),
            .up_vld (ext_vld[i+2]),
            .up_val (ext_val[i+2]),
            .up_age (ext_age[i+2]),
            .vld    (ext_vld[i+1]),
            .val    (ext_val[i+1]),
            .age    (ext_age[i+1])
        );

        assign vld_all[i] = ext_vld[i+1];
        assign val_all[i] = ext_val[i+1];

        if (i + 1 < MAX_WINDOW)
        begin : g_gap
            assign gap_bits[i] = !ext_vld[i+1] && ext_vld[i+2];
        end
        else
        begin : g_gap_top
            assign gap_bits[i] = 1'b0;
        end
    end

    assign gap  = |gap_bits;
    assign full = vld_all[k_lim];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swmed_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = swmed_pkg::ST_COMPACT;
                end
            end
            swmed_pkg::ST_COMPACT:
            begin
                if (!gap)
                begin
                    state_next = swmed_pkg::ST_PICK;
                end
            end
            swmed_pkg::ST_PICK:
            begin
                // hold while a full window waits for the output register
                if (!full || !out_valid || out_ready)
                begin
                    state_next = swmed_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmed_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready          = 1'b0;
        cell_ctrl.op      = swmed_pkg::OP_HOLD;
        cell_ctrl.restart = restart;
        pick_load         = 1'b0;
        unique case (state_reg)
            swmed_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cell_ctrl.op = swmed_pkg::OP_EVICT;
                end
            end
            swmed_pkg::ST_COMPACT:
            begin
                cell_ctrl.op = gap ? swmed_pkg::OP_COMPACT : swmed_pkg::OP_INSERT;
            end
            swmed_pkg::ST_PICK:
            begin
                pick_load = full && (!out_valid || out_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign sample_next = (in_valid && in_ready) ? sample : sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmed_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    // Output register
    logic signed [SAMPLE_BITS-1:0] lo_val;
    logic signed [SAMPLE_BITS-1:0] hi_val;
    logic signed [SAMPLE_BITS:0]   sum;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS:0]   median_reg;
    logic signed [SAMPLE_BITS:0]   median_next;

    assign lo_val = val_all[lo_idx];
    assign hi_val = val_all[hi_idx];
    assign sum    = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

    always_comb
    begin
        priority if (pick_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign median_next = pick_load ? sum : median_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;

    // Checks
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is still being placed");

    a_restart_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> vld_all == '0)
        else $error("restart left samples in the window");

    a_pick_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == swmed_pkg::ST_PICK |-> !gap && vld_all[0])
        else $error("window not packed when the median is picked");

    a_insert_packed: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.op == swmed_pkg::OP_INSERT |-> !gap)
        else $error("insert issued into a chain with holes");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the sliding-window median filter: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

class median_scoreboard;
    localparam int DEPTH = 64;

    bit [6:0]           window_cfg;
    logic signed [15:0] arrival [DEPTH];
    int                 ordered_q [$];
    int unsigned        write_slot;
    logic signed [16:0] median_q [$];
    int                 mismatches;
    int                 checked;
    int                 taken;

    function new();
        window_cfg = swmed_pkg::WINDOW_SIZE_RESET;
        write_slot = 0;
        mismatches = 0;
        checked    = 0;
        taken      = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function int unsigned span();
        if (window_cfg == 0) return 1;
        if (window_cfg > DEPTH) return DEPTH;
        return window_cfg;
    endfunction

    function void drop_oldest();
        int unsigned slot;
        int          val;
        int          pos;
        if (ordered_q.size() == 0) return;
        slot = (write_slot + DEPTH - ordered_q.size()) % DEPTH;
        val  = arrival[slot];
        pos  = 0;
        // any copy of a repeated value will do
        while (pos < ordered_q.size() - 1 && ordered_q[pos] != val) pos++;
        ordered_q.delete(pos);
    endfunction

    function void note_input(logic signed [15:0] value, bit restart_flag);
        int unsigned k;
        int          pos;
        int          twice;
        k = span();
        taken++;
        if (restart_flag) begin
            ordered_q.delete();
            write_slot = 0;
        end
        while (ordered_q.size() >= k) drop_oldest();
        pos = ordered_q.size();
        while (pos > 0 && ordered_q[pos-1] > value) pos--;
        ordered_q.insert(pos, value);
        arrival[write_slot] = value;
        write_slot = (write_slot + 1) % DEPTH;
        if (ordered_q.size() != k) return;
        if (k % 2 == 1)
            twice = 2 * ordered_q[k/2];
        else
            twice = ordered_q[k/2-1] + ordered_q[k/2];
        median_q.insert(median_q.size(), 17'(twice));
    endfunction

    task check_result(logic signed [16:0] got);
        logic signed [16:0] want;
        if (median_q.size() == 0) begin
            report($sformatf("median_doubled %0d arrived with none pending", got));
            return;
        end
        want = median_q.pop_front();
        checked++;
        if (got !== want)
            report($sformatf("median_doubled %0d, predicted %0d (result %0d)",
                             got, want, checked));
    endtask
endclass

module tb;

    localparam int          SAMPLE_W    = 16;
    localparam int          RANDOM_ITEMS = 900;
    localparam int          SETTLE      = 100;
    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [swmed_pkg::ADDR_BITS-1:0] WINDOW_ADDR =
        {swmed_pkg::REG_WINDOW_SIZE, 2'b00};

    typedef enum int {MIX_FULL, MIX_NARROW, MIX_EDGE} sample_mix_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [swmed_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0]                pwdata    = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       restart   = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W:0]   median_doubled;
    logic                       out_valid;
    logic                       out_ready = 1'b0;

    bit                idle_on  = 1'b1;
    int                settings = 0;
    int                cycles   = 0;
    median_scoreboard  sb       = new();

    sliding_window_median_top #(
        .MAX_WINDOW  (64),
        .SAMPLE_BITS (SAMPLE_W)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample         (sample),
        .restart        (restart),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .median_doubled (median_doubled),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // check each output transfer, then stall the receiver now and then
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(median_doubled);
        out_ready <= !(idle_on && $urandom_range(99) < 6);
    end

    task automatic write_window(bit [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        // upper bits are don't-care for a 7-bit register
        pwdata  <= {25'($urandom_range(0, 2**25 - 1)), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.window_cfg = value;
        settings++;
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] value, bit restart_flag);
        if (idle_on && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        restart  <= restart_flag;
        do @(posedge clk); while (!in_ready);
        sb.note_input(value, restart_flag);
    endtask

    task automatic stop_samples();
        in_valid <= 1'b0;
    endtask

    // hold until every predicted median is out, then let the chain settle
    task automatic wait_idle();
        while (sb.median_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_mix_t mix);
        case (mix)
            MIX_FULL:   return SAMPLE_W'($urandom);
            MIX_NARROW: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
            default:
                case ($urandom_range(0, 3))
                    0:       return -16'sd32768;
                    1:       return 16'sd32767;
                    2:       return 16'sd0;
                    default: return -16'sd1;
                endcase
        endcase
    endfunction

    function automatic sample_mix_t pick_mix();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return MIX_FULL;
        if (r < 8) return MIX_NARROW;
        return MIX_EDGE;
    endfunction

    function automatic bit [6:0] pick_window();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd2;
            3, 4:    return 7'd64;
            5:       return 7'($urandom_range(65, 127));
            6:       return 7'd127;
            7, 8, 9, 10, 11, 12: return 7'($urandom_range(3, 9));
            13, 14, 15: return 7'($urandom_range(10, 20));
            default: return 7'($urandom_range(21, 64));
        endcase
    endfunction

    initial
    begin
        int          sent;
        int          phase_len;
        bit          restart_flag;
        bit          fresh;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // odd window at its reset size, extreme values and repeated values
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        stop_samples();
        wait_idle();

        // even window: mean of the two extremes
        write_window(7'd2);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        stop_samples();
        wait_idle();

        // shrink a full window without restart
        write_window(7'd4);
        send_sample(16'sd10, 1'b1);
        send_sample(16'sd20, 1'b0);
        send_sample(16'sd30, 1'b0);
        send_sample(16'sd40, 1'b0);
        stop_samples();
        wait_idle();
        write_window(7'd2);
        send_sample(16'sd50, 1'b0);
        stop_samples();
        wait_idle();

        // zero size acts as one
        write_window(7'd0);
        send_sample(-16'sd5, 1'b1);
        send_sample(16'sd9, 1'b0);
        stop_samples();
        wait_idle();

        // oversize window never fills here, then shrink to one without restart
        write_window(7'd127);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b0);
        stop_samples();
        wait_idle();
        write_window(7'd1);
        send_sample(16'sd4, 1'b0);
        stop_samples();
        wait_idle();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // quiet stretch: neither side idles
            idle_on = !(sent >= 300 && sent < 450);
            write_window(pick_window());
            fresh     = $urandom_range(0, 99) < 85;
            phase_len = sb.span() + $urandom_range(4, 30);
            for (int i = 0; i < phase_len; i++)
            begin
                restart_flag = (i == 0) ? fresh : ($urandom_range(0, 99) < 2);
                send_sample(pick_sample(pick_mix()), restart_flag);
                sent++;
            end
            stop_samples();
            wait_idle();
        end

        if (sb.median_q.size() != 0)
            sb.report($sformatf("%0d predicted medians never arrived", sb.median_q.size()));
        $display("Ran %0d samples through %0d window settings (sizes 0 to 127, with restarts);",
                 sb.taken, settings);
        $display("compared %0d medians, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[filelist.f]
src/swmed_pkg.sv
src/swmed_cell.sv
src/sliding_window_median_top.sv
tb/sv/tb.sv
